@@ rtl/core/pms_pkg.sv @@
// ----------------------------------------------------------------------------
// Potts sampler package
// Shared constants, operation codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

	localparam int unsigned MaxSitesDefault  = 16;
	localparam int unsigned MaxStatesDefault = 8;
	localparam int unsigned ValueW   = 24;
	localparam int unsigned DeltaW   = 32;
	localparam int unsigned UniformW = 16;

	localparam logic [2:0] OP_LOAD_FIELD    = 3'd0;
	localparam logic [2:0] OP_LOAD_COUPLING = 3'd1;
	localparam logic [2:0] OP_LOAD_SPIN     = 3'd2;
	localparam logic [2:0] OP_READ_SPIN     = 3'd3;
	localparam logic [2:0] OP_TRIAL         = 3'd4;

	localparam logic REG_SITES  = 1'b0;
	localparam logic REG_STATES = 1'b1;

	localparam logic [2:0] CP_CLEAR  = 3'd0;
	localparam logic [2:0] CP_FIELD  = 3'd1;
	localparam logic [2:0] CP_COUPLE = 3'd2;
	localparam logic [2:0] CP_SAT    = 3'd3;
	localparam logic [2:0] CP_EXP    = 3'd4;
	localparam logic [2:0] CP_NONE   = 3'd5;

	typedef struct packed {
		logic       capture;
		logic       rd_field;
		logic       rd_old;
		logic       rd_coup;
		logic       site_step;
		logic [2:0] acc_op;
		logic       exp_start;
		logic       write_back;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic is_trial;
		logic is_load;
		logic last_site;
		logic exp_done;
	} status_t;

	// Reciprocals floor(2^32/k) for the Taylor division, k = 1..10.
	function automatic logic [32:0] recip(input logic [3:0] k);
		logic [32:0] r;
		begin
			case (k)
				4'd1:    r = 33'd4294967296;
				4'd2:    r = 33'd2147483648;
				4'd3:    r = 33'd1431655765;
				4'd4:    r = 33'd1073741824;
				4'd5:    r = 33'd858993459;
				4'd6:    r = 33'd715827882;
				4'd7:    r = 33'd613566756;
				4'd8:    r = 33'd536870912;
				4'd9:    r = 33'd477218588;
				default: r = 33'd429496729;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/potts_metropolis_sampler_core.sv @@
// ----------------------------------------------------------------------------
// Potts Metropolis sampler core
// Single-site Metropolis trials over stored field and coupling tables.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// request   start / busy          operation site state other_site other_state
//                                  value offset uniform
// result    done (one cycle)      out_site spin_state accepted energy_change status
// config    cfg_valid/cfg_ready   cfg_index cfg_data
//
// A load or read passes through decode and finish. A trial's length is set by
// the coupling memory port (two reads per site) and the iterative exponential.
// Reset zeroes the spins and sets 16 sites and 8 states; tables are undefined
// until written.
// The result cannot be stalled and is shown with done for one cycle.
`default_nettype none

module potts_metropolis_sampler_core #(
	parameter int unsigned MAX_SITES  = pms_pkg::MaxSitesDefault,
	parameter int unsigned MAX_STATES = pms_pkg::MaxStatesDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [2:0]          operation,
	input  wire logic [3:0]          site,
	input  wire logic [2:0]          state,
	input  wire logic [3:0]          other_site,
	input  wire logic [2:0]          other_state,
	input  wire logic signed [23:0]  value,
	input  wire logic [2:0]          offset,
	input  wire logic [15:0]         uniform,
	output logic                     done,
	output logic [3:0]               out_site,
	output logic [2:0]               spin_state,
	output logic                     accepted,
	output logic signed [31:0]       energy_change,
	output logic                     status,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [4:0]          cfg_data
);
	import pms_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	pms_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.sts   (sts)
	);

	pms_datapath #(.MAX_SITES(MAX_SITES), .MAX_STATES(MAX_STATES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.site         (site),
		.state        (state),
		.other_site   (other_site),
		.other_state  (other_state),
		.value        (value),
		.offset       (offset),
		.uniform      (uniform),
		.out_site     (out_site),
		.spin_state   (spin_state),
		.accepted     (accepted),
		.energy_change(energy_change),
		.status       (status)
	);

endmodule

`default_nettype wire

@@ rtl/core/pms_exp.sv @@
// ----------------------------------------------------------------------------
// Potts sampler acceptance unit
// Iterative fixed-point exp(-d) as a Taylor sum, each term by multiply, divide and fix.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_exp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pms_pkg::DeltaW-1:0]  delta,
	output logic                             done,
	output logic [15:0]                      prob
);
	import pms_pkg::*;

	typedef enum logic [2:0] {
		E_IDLE, E_Y, E_T, E_MUL, E_DIV, E_FIX, E_SHIFT, E_PROB
	} estate_t;

	estate_t     state_q;
	logic [31:0] x_q;
	logic [35:0] y_q;
	logic [30:0] t_q;
	logic [30:0] term_q;
	logic [61:0] prod_q;
	logic [32:0] sum_q;
	logic [3:0]  k_q;
	logic [31:0] q_q;
	logic [31:0] r_q;
	logic        zero_q;
	logic [61:0] q_full;
	logic [31:0] q_est;
	logic [61:0] q_chk;

	assign q_full = prod_q >> 30;
	assign q_est  = 32'((63'(q_full[29:0]) * 63'(recip(k_q))) >> 32);
	assign q_chk  = 62'(q_q + 32'd1) * 62'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						x_q     <= delta;
						zero_q  <= delta >= 32'h0010_0000;
						state_q <= E_Y;
					end
				end
				E_Y: begin
					y_q     <= 36'((48'(x_q[20:0]) * 48'd94548) >> 16);
					state_q <= E_T;
				end
				E_T: begin
					t_q     <= 31'((48'(y_q[15:0]) * 48'd744261118) >> 16);
					term_q  <= 31'h4000_0000;
					sum_q   <= 33'h0_4000_0000;
					k_q     <= 4'd1;
					state_q <= E_MUL;
				end
				E_MUL: begin
					prod_q  <= 62'(term_q) * 62'(t_q);
					state_q <= E_DIV;
				end
				E_DIV: begin
					q_q     <= q_est;
					state_q <= E_FIX;
				end
				E_FIX: begin
					logic [30:0] nt;
					nt = (q_chk <= 62'(q_full[31:0])) ? 31'(q_q + 32'd1) : 31'(q_q);
					term_q <= nt;
					if (k_q[0]) sum_q <= sum_q - 33'(nt);
					else        sum_q <= sum_q + 33'(nt);
					if (k_q == 4'd10) state_q <= E_SHIFT;
					else begin
						k_q     <= k_q + 4'd1;
						state_q <= E_MUL;
					end
				end
				E_SHIFT: begin
					r_q     <= 32'(sum_q >> y_q[20:16]);
					state_q <= E_PROB;
				end
				default: begin
					prob    <= zero_q ? 16'd0 : 16'((48'(r_q) * 48'd65535) >> 30);
					done    <= 1'b1;
					state_q <= E_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pms_datapath.sv @@
// ----------------------------------------------------------------------------
// Potts sampler datapath
// Spin registers, field and coupling memories, energy accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_datapath #(
	parameter int unsigned MAX_SITES  = pms_pkg::MaxSitesDefault,
	parameter int unsigned MAX_STATES = pms_pkg::MaxStatesDefault
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pms_pkg::cmd_t         cmd,
	output pms_pkg::status_t           sts,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_index,
	input  wire logic [4:0]            cfg_data,
	input  wire logic [2:0]            operation,
	input  wire logic [3:0]            site,
	input  wire logic [2:0]            state,
	input  wire logic [3:0]            other_site,
	input  wire logic [2:0]            other_state,
	input  wire logic signed [23:0]    value,
	input  wire logic [2:0]            offset,
	input  wire logic [15:0]           uniform,
	output logic [3:0]                 out_site,
	output logic [2:0]                 spin_state,
	output logic                       accepted,
	output logic signed [31:0]         energy_change,
	output logic                       status
);
	import pms_pkg::*;

	localparam int unsigned SW   = $clog2(MAX_SITES);
	localparam int unsigned QW   = $clog2(MAX_STATES);
	localparam int unsigned RW   = SW + QW;
	localparam int unsigned ROWS = MAX_SITES * MAX_STATES;
	localparam int unsigned CW   = $clog2(MAX_SITES + 1);
	localparam int unsigned NW   = $clog2(MAX_STATES + 1);

	logic [4:0]            sites_q;
	logic [3:0]            states_q;
	logic [QW-1:0]         spins_q [MAX_SITES];
	logic [ValueW-1:0]     field_mem [ROWS];
	logic [ValueW-1:0]     coup_mem [ROWS*ROWS];
	logic [ValueW-1:0]     frd_q;
	logic [ValueW-1:0]     crd_q;
	logic [2:0]            op_q;
	logic [3:0]            site_q;
	logic [2:0]            st_q;
	logic [3:0]            osite_q;
	logic [2:0]            ost_q;
	logic [ValueW-1:0]     val_q;
	logic [2:0]            off_q;
	logic [15:0]           uni_q;
	logic                  bad_q;
	logic [QW-1:0]         old_q;
	logic [QW-1:0]         new_q;
	logic [SW-1:0]         i_q;
	logic                  ph_q;
	logic                  in_q;
	logic signed [39:0]    acc_q;
	logic                  acc_ok_q;
	logic signed [31:0]    d_q;
	logic                  exp_done;
	logic [15:0]           prob;
	logic [CW-1:0]         s_eff;
	logic [NW-1:0]         q_eff;
	logic                  bad;
	logic [SW-1:0]         p_s;
	logic [RW-1:0]         prow;
	logic [RW-1:0]         orow;
	logic [RW-1:0]         frow;
	logic [QW:0]           nsum;
	logic [QW-1:0]         nsel;
	logic [5:0]            nrem;

	assign s_eff = (32'(sites_q) > MAX_SITES) ? CW'(MAX_SITES) : CW'(sites_q);
	assign q_eff = (32'(states_q) > MAX_STATES) ? NW'(MAX_STATES) : NW'(states_q);

	always_comb begin
		bad = 32'(site) >= 32'(s_eff);
		unique case (operation)
			OP_LOAD_FIELD, OP_LOAD_SPIN: bad = bad || (32'(state) >= 32'(q_eff));
			OP_LOAD_COUPLING: bad = bad || (32'(state) >= 32'(q_eff))
				|| (32'(other_state) >= 32'(q_eff)) || (32'(other_site) >= 32'(s_eff));
			OP_READ_SPIN: ;
			OP_TRIAL: bad = bad || (q_eff < NW'(2)) || (32'(offset) + 1 >= 32'(q_eff));
			default: bad = 1'b1;
		endcase
	end

	assign p_s  = SW'(site_q);
	assign nsum = (QW+1)'(32'(spins_q[p_s]) + 32'(off_q) + 1);

	// A stale spin above the state count can push the sum past twice the count.
	always_comb begin
		nrem = 6'(nsum);
		for (int b = 2; b >= 0; b--) begin
			if (nrem >= (6'(q_eff) << b)) nrem = nrem - (6'(q_eff) << b);
		end
		nsel = QW'(nrem);
	end

	assign frow = {p_s, ph_q ? new_q : old_q};

	always_comb begin
		if (i_q < p_s) begin
			prow = {i_q, spins_q[i_q]};
			orow = {p_s, ph_q ? new_q : old_q};
		end else begin
			prow = {p_s, ph_q ? new_q : old_q};
			orow = {i_q, spins_q[i_q]};
		end
	end

	assign sts.bad       = bad_q;
	assign sts.is_trial  = op_q == OP_TRIAL;
	assign sts.is_load   = op_q == OP_LOAD_FIELD || op_q == OP_LOAD_COUPLING
		|| op_q == OP_LOAD_SPIN;
	assign sts.last_site = ph_q && (32'(i_q) + 1 >= 32'(s_eff));
	assign sts.exp_done  = exp_done;

	always_ff @(posedge clk) begin
		if (cmd.rd_field) frd_q <= field_mem[frow];
		if (cmd.rd_coup)  crd_q <= coup_mem[{prow, orow}];
		if (cmd.write_back && !bad_q) begin
			if (op_q == OP_LOAD_FIELD)
				field_mem[{SW'(site_q), QW'(st_q)}] <= val_q;
			if (op_q == OP_LOAD_COUPLING)
				coup_mem[{SW'(site_q), QW'(st_q), SW'(osite_q), QW'(ost_q)}] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sites_q  <= 5'd16;
			states_q <= 4'd8;
			for (int k = 0; k < MAX_SITES; k++) spins_q[k] <= '0;
			out_site      <= '0;
			spin_state    <= '0;
			accepted      <= 1'b0;
			energy_change <= '0;
			status        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_SITES) sites_q <= cfg_data;
				else                        states_q <= cfg_data[3:0];
			end
			if (cmd.capture) begin
				op_q <= operation; site_q <= site; st_q <= state; osite_q <= other_site;
				ost_q <= other_state; val_q <= value; off_q <= offset; uni_q <= uniform;
				bad_q <= bad;
			end
			if (cmd.rd_old) begin
				old_q <= spins_q[p_s];
				new_q <= nsel;
				i_q   <= '0;
				ph_q  <= 1'b0;
			end
			if (cmd.rd_field) ph_q <= ~ph_q;
			if (cmd.site_step) begin
				ph_q <= ~ph_q;
				if (ph_q) i_q <= i_q + SW'(1);
			end
			in_q <= cmd.rd_coup && (i_q != p_s);
			unique case (cmd.acc_op)
				CP_CLEAR: acc_q <= '0;
				CP_FIELD: acc_q <= ph_q ? acc_q + 40'(signed'(frd_q))
				                        : acc_q - 40'(signed'(frd_q));
				CP_COUPLE: if (in_q) acc_q <= ph_q ? acc_q + 40'(signed'(crd_q))
				                                    : acc_q - 40'(signed'(crd_q));
				CP_SAT: begin
					if (acc_q > 40'sh007FFFFFFF) d_q <= 32'sh7FFFFFFF;
					else if (acc_q < -40'sh0080000000) d_q <= 32'sh80000000;
					else d_q <= 32'(acc_q);
				end
				default: ;
			endcase
			if (exp_done) acc_ok_q <= d_q[31] || (prob > uni_q);
			if (cmd.write_back && !bad_q && op_q == OP_LOAD_SPIN)
				spins_q[SW'(site_q)] <= QW'(st_q);
			if (cmd.acc_op == CP_EXP && acc_ok_q) spins_q[p_s] <= new_q;
			if (cmd.finish) begin
				out_site      <= site_q;
				spin_state    <= (32'(site_q) < MAX_SITES) ? 3'(spins_q[SW'(site_q)]) : 3'd0;
				status        <= bad_q;
				accepted      <= !bad_q && sts.is_trial && acc_ok_q;
				energy_change <= (!bad_q && sts.is_trial) ? d_q : '0;
			end
		end
	end

	pms_exp u_exp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.exp_start),
		.delta (d_q),
		.done  (exp_done),
		.prob  (prob)
	);

endmodule

`default_nettype wire

@@ rtl/core/pms_ctrl.sv @@
// ----------------------------------------------------------------------------
// Potts sampler controller
// Sequences loads, reads and trial scans over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output pms_pkg::cmd_t          cmd,
	input  wire pms_pkg::status_t  sts
);
	import pms_pkg::*;

	typedef enum logic [3:0] {
		C_IDLE, C_DECODE, C_OLD, C_F0, C_F1, C_F2, C_SCAN, C_DRAIN1, C_DRAIN2,
		C_SAT, C_EXPGO, C_EXPWAIT, C_APPLY, C_FINISH, C_DONE
	} cstate_t;

	cstate_t state_q;

	always_comb begin
		cmd = '0;
		cmd.acc_op = CP_NONE;
		unique case (state_q)
			C_IDLE:    cmd.capture = start;
			C_DECODE:  cmd.write_back = sts.is_load;
			C_OLD:     begin cmd.rd_old = 1'b1; cmd.acc_op = CP_CLEAR; end
			C_F0:      cmd.rd_field = 1'b1;
			C_F1:      begin cmd.rd_field = 1'b1; cmd.acc_op = CP_FIELD; end
			C_F2:      cmd.acc_op = CP_FIELD;
			C_SCAN:    begin cmd.rd_coup = 1'b1; cmd.site_step = 1'b1;
			           cmd.acc_op = CP_COUPLE; end
			C_DRAIN1:  cmd.acc_op = CP_COUPLE;
			C_DRAIN2:  cmd.acc_op = CP_COUPLE;
			C_SAT:     cmd.acc_op = CP_SAT;
			C_EXPGO:   cmd.exp_start = 1'b1;
			C_APPLY:   cmd.acc_op = CP_EXP;
			C_FINISH:  cmd.finish = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				C_IDLE:   if (start) begin state_q <= C_DECODE; busy <= 1'b1; end
				C_DECODE: state_q <= (sts.is_trial && !sts.bad) ? C_OLD : C_FINISH;
				C_OLD:    state_q <= C_F0;
				C_F0:     state_q <= C_F1;
				C_F1:     state_q <= C_F2;
				C_F2:     state_q <= C_SCAN;
				C_SCAN:   if (sts.last_site) state_q <= C_DRAIN1;
				C_DRAIN1: state_q <= C_DRAIN2;
				C_DRAIN2: state_q <= C_SAT;
				C_SAT:    state_q <= C_EXPGO;
				C_EXPGO:  state_q <= C_EXPWAIT;
				C_EXPWAIT: if (sts.exp_done) state_q <= C_APPLY;
				C_APPLY:  state_q <= C_FINISH;
				C_FINISH: begin state_q <= C_DONE; end
				default:  begin state_q <= C_IDLE; busy <= 1'b0; done <= 1'b1; end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pms_checker.sv @@
// ----------------------------------------------------------------------------
// Potts sampler port checker
// Checks request and result sequencing and error-result contents at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        accepted,
	input wire logic        status,
	input wire logic [31:0] energy_change
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result shown twice");
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy with result");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !accepted && energy_change == 32'd0)
		else $error("error result carries data");

endmodule

bind potts_metropolis_sampler_core pms_checker u_pms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.accepted     (accepted),
	.status       (status),
	.energy_change(energy_change)
);

`default_nettype wire
